// ===== rtl/drt_pkg.sv =====
// Shared types, constants and codes for the divider and reload timer.
package drt_pkg;

    localparam int ACCUM_WIDTH    = 16;
    localparam int DIVIDER_PERIOD = 256;
    localparam int CPU_CLOCK_HZ   = 4194304;

    // Compare width wide enough for any accumulator sum and any period.
    localparam int CMP_W = 33;

    localparam int RATE0_HZ = 4096;
    localparam int RATE1_HZ = 262144;
    localparam int RATE2_HZ = 65536;
    localparam int RATE3_HZ = 16384;

    localparam int RATE0_RAW = CPU_CLOCK_HZ / RATE0_HZ;
    localparam int RATE1_RAW = CPU_CLOCK_HZ / RATE1_HZ;
    localparam int RATE2_RAW = CPU_CLOCK_HZ / RATE2_HZ;
    localparam int RATE3_RAW = CPU_CLOCK_HZ / RATE3_HZ;

    // A period that rounds down to zero behaves as a period of one.
    localparam int RATE0_PERIOD = (RATE0_RAW == 0) ? 1 : RATE0_RAW;
    localparam int RATE1_PERIOD = (RATE1_RAW == 0) ? 1 : RATE1_RAW;
    localparam int RATE2_PERIOD = (RATE2_RAW == 0) ? 1 : RATE2_RAW;
    localparam int RATE3_PERIOD = (RATE3_RAW == 0) ? 1 : RATE3_RAW;

    localparam logic [7:0] COUNTER_MAX = 8'hFF;

    typedef logic [ACCUM_WIDTH-1:0] t_accum;
    typedef logic [ACCUM_WIDTH:0]   t_accum_sum;
    typedef logic [CMP_W-1:0]       t_period;

    localparam t_period DIVIDER_PERIOD_C = t_period'(DIVIDER_PERIOD);

    localparam t_period RATE_PERIOD [4] = '{
        t_period'(RATE0_PERIOD),
        t_period'(RATE1_PERIOD),
        t_period'(RATE2_PERIOD),
        t_period'(RATE3_PERIOD)
    };

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        REG_DIVIDER = 2'd0,
        REG_COUNTER = 2'd1,
        REG_RELOAD  = 2'd2,
        REG_CONTROL = 2'd3
    } t_reg_sel;

    localparam int CTRL_ENABLE_BIT = 2;

    typedef struct packed {
        t_opcode    opcode;
        t_reg_sel   reg_select;
        logic [7:0] write_data;
        logic [7:0] cycles;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } t_out_word;

    typedef struct packed {
        t_accum acc;
        logic   hit;
    } t_step_res;

endpackage

// ===== rtl/drt_ifs.sv =====
// Valid/ready channel interfaces for the timer's input and result words.
interface drt_in_if import drt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface drt_out_if import drt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/divider_and_reload_timer_unit.sv =====
// A word accepted into the input register moves on to the result register when that
// register frees up, and its result is offered from there.
// Throughput: one word per cycle, sustained while the result side takes words.
// The input register and the result register each hold one word, so input
// ready only drops when both are full and the result is not taken.
// Reset (i_rst_n low, synchronous) clears both valid flags and all timer
// state: accumulators, divider, counter, reload, control and rate selection.
module divider_and_reload_timer_unit import drt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    drt_in_if.sink    i_in,
    drt_out_if.source o_out
);

    // Input register stage.
    logic     r_s1_valid;
    t_in_word r_s1_item;

    // Result register stage.
    logic      r_out_valid;
    t_out_word r_out_item;
    t_out_word n_out_item;

    // Timer state.
    t_accum     r_div_accum,  n_div_accum;
    t_accum     r_cnt_accum,  n_cnt_accum;
    logic [7:0] r_div_value,  n_div_value;
    logic [7:0] r_cnt_value,  n_cnt_value;
    logic [7:0] r_reload,     n_reload;
    logic [7:0] r_control,    n_control;
    logic [1:0] r_active_sel, n_active_sel;

    logic       s1_adv;
    logic       s1_fire;
    logic       in_fire;
    logic [1:0] new_sel;
    t_accum     cnt_base;
    t_step_res  div_res;
    t_step_res  cnt_res;

    // The result register frees up when it is empty or being taken; the
    // input register moves forward at the same moment.
    assign s1_adv  = !r_out_valid || o_out.ready;
    assign s1_fire = r_s1_valid && s1_adv;
    assign in_fire = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // A change of rate selection restarts the counter accumulator, even when
    // the counter is disabled.
    assign new_sel  = r_control[1:0];
    assign cnt_base = (new_sel != r_active_sel) ? '0 : r_cnt_accum;

    drt_accum u_div_accum (
        .i_acc    (r_div_accum),
        .i_cycles (r_s1_item.cycles),
        .i_period (DIVIDER_PERIOD_C),
        .o_res    (div_res)
    );

    drt_accum u_cnt_accum (
        .i_acc    (cnt_base),
        .i_cycles (r_s1_item.cycles),
        .i_period (RATE_PERIOD[new_sel]),
        .o_res    (cnt_res)
    );

    // Work for the word in the input register. Only the tick touches the
    // accumulators; reads and writes touch the byte registers.
    always_comb begin
        n_div_accum  = r_div_accum;
        n_cnt_accum  = r_cnt_accum;
        n_div_value  = r_div_value;
        n_cnt_value  = r_cnt_value;
        n_reload     = r_reload;
        n_control    = r_control;
        n_active_sel = r_active_sel;
        n_out_item   = '0;

        unique case (r_s1_item.opcode)
            OP_TICK: begin
                n_div_accum = div_res.acc;
                if (div_res.hit) begin
                    n_div_value = r_div_value + 8'd1;
                end
                n_active_sel = new_sel;
                n_cnt_accum  = cnt_base;
                if (r_control[CTRL_ENABLE_BIT]) begin
                    n_cnt_accum = cnt_res.acc;
                    if (cnt_res.hit) begin
                        // Stepping past the top reloads and raises the interrupt.
                        if (r_cnt_value == COUNTER_MAX) begin
                            n_cnt_value          = r_reload;
                            n_out_item.timer_irq = 1'b1;
                        end else begin
                            n_cnt_value = r_cnt_value + 8'd1;
                        end
                    end
                end
            end
            OP_READ: begin
                unique case (r_s1_item.reg_select)
                    REG_DIVIDER: n_out_item.read_data = r_div_value;
                    REG_COUNTER: n_out_item.read_data = r_cnt_value;
                    REG_RELOAD:  n_out_item.read_data = r_reload;
                    REG_CONTROL: n_out_item.read_data = r_control;
                    default:     n_out_item.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                // Any write to the divider clears it; its accumulator is kept.
                unique case (r_s1_item.reg_select)
                    REG_DIVIDER: n_div_value = '0;
                    REG_COUNTER: n_cnt_value = r_s1_item.write_data;
                    REG_RELOAD:  n_reload    = r_s1_item.write_data;
                    REG_CONTROL: n_control   = r_s1_item.write_data;
                    default:     n_control   = r_control;
                endcase
            end
            default: begin
                // The unused opcode leaves everything as it is.
                n_out_item = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_div_accum  <= '0;
            r_cnt_accum  <= '0;
            r_div_value  <= '0;
            r_cnt_value  <= '0;
            r_reload     <= '0;
            r_control    <= '0;
            r_active_sel <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_div_accum  <= n_div_accum;
                r_cnt_accum  <= n_cnt_accum;
                r_div_value  <= n_div_value;
                r_cnt_value  <= n_cnt_value;
                r_reload     <= n_reload;
                r_control    <= n_control;
                r_active_sel <= n_active_sel;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in.data;
        end
        if (s1_fire) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// ===== rtl/drt_accum.sv =====
// Saturating cycle accumulator step: add, clamp, and take off one period.
module drt_accum import drt_pkg::*; (
    input  t_accum     i_acc,
    input  logic [7:0] i_cycles,
    input  t_period    i_period,
    output t_step_res  o_res
);

    t_accum_sum sum;
    t_accum     sat;
    t_period    sat_ext;
    t_period    diff;

    always_comb begin
        sum     = t_accum_sum'(i_acc) + t_accum_sum'(i_cycles);
        sat     = sum[ACCUM_WIDTH] ? '1 : sum[ACCUM_WIDTH-1:0];
        sat_ext = t_period'(sat);
        diff    = sat_ext - i_period;
        o_res.hit = (sat_ext >= i_period);
        o_res.acc = o_res.hit ? diff[ACCUM_WIDTH-1:0] : sat;
    end

endmodule

// ===== rtl/drt_checker.sv =====
// Port-level checks for the timer, bound to the top level.
module drt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_read_data,
    input logic       i_out_timer_irq
);

    // A result word that is not taken stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_read_data) && $stable(i_out_timer_irq)))
        else $error("result word changed while stalled");

    // A result never carries both read data and an interrupt.
    a_irq_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_timer_irq) |-> (i_out_read_data == 8'd0))
        else $error("interrupt result with nonzero read data");

    // While the result side takes words, the input side never stalls.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while result side is ready");

    // An accepted word moves into the result register at the next edge when
    // the result side takes words at that edge.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_in_valid && i_in_ready) ##1 i_out_ready) |=> i_out_valid)
        else $error("accepted word did not produce a result");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind divider_and_reload_timer_unit drt_checker u_drt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_read_data (o_out.data.read_data),
    .i_out_timer_irq (o_out.data.timer_irq)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the divider and reload timer unit.
module tb_top;
    import drt_pkg::*;

    // The run gives up well past the slowest correct run (about 450 words, each
    // with sender gaps and receiver stalls, plus the long receiver hold-off).
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int          IDLE_PCT     = 31;

    // Opcode 3 has no enum member; the block must treat it as a no-op.
    localparam t_opcode OP_UNUSED = t_opcode'(2'd3);

    // Counter rates in Hz, indexed by control bits 1:0.
    localparam int unsigned TIMER_RATE_HZ [4] = '{4096, 262144, 65536, 16384};
    localparam int unsigned ACCUM_MAX = (1 << ACCUM_WIDTH) - 1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    drt_in_if  in_ch ();
    drt_out_if out_ch ();

    divider_and_reload_timer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the timer state, advanced once per accepted word.
    int unsigned shadow_div_acc;
    int unsigned shadow_cnt_acc;
    logic [7:0]  shadow_divider;
    logic [7:0]  shadow_counter;
    logic [7:0]  shadow_reload;
    logic [7:0]  shadow_control;
    logic [1:0]  shadow_rate_sel;

    // Result words still owed by the block, oldest first.
    t_out_word pending_results [$];
    t_out_word exp_word;

    int idle_pct = IDLE_PCT;
    int unsigned hold_requests = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int unsigned reads_sent = 0;
    int unsigned results_seen = 0;
    int unsigned overflows_seen = 0;

    // Adds cycles to an accumulator with saturation and reports whether a full
    // period was reached; at most one period is taken per call.
    function automatic logic accum_advance(inout int unsigned acc,
                                           input int unsigned add,
                                           input int unsigned period);
        int unsigned sum;
        sum = acc + add;
        if (sum > ACCUM_MAX) sum = ACCUM_MAX;
        if (sum >= period) begin
            acc = sum - period;
            return 1'b1;
        end
        acc = sum;
        return 1'b0;
    endfunction

    // Works out the result word for one input word and updates the shadow state.
    function automatic t_out_word predict_timer_result(t_in_word w);
        t_out_word   r;
        int unsigned period;
        logic [1:0]  new_sel;
        r = '0;
        case (w.opcode)
            OP_TICK: begin
                new_sel = shadow_control[1:0];
                if (accum_advance(shadow_div_acc, w.cycles, DIVIDER_PERIOD))
                    shadow_divider = shadow_divider + 8'd1;
                // A new rate selection restarts the counter accumulator, even
                // while the timer is disabled.
                if (new_sel != shadow_rate_sel) begin
                    shadow_cnt_acc  = 0;
                    shadow_rate_sel = new_sel;
                end
                if (shadow_control[CTRL_ENABLE_BIT]) begin
                    period = CPU_CLOCK_HZ / TIMER_RATE_HZ[shadow_rate_sel];
                    if (period == 0) period = 1;
                    if (accum_advance(shadow_cnt_acc, w.cycles, period)) begin
                        if (shadow_counter == 8'hFF) begin
                            shadow_counter = shadow_reload;
                            r.timer_irq    = 1'b1;
                        end else begin
                            shadow_counter = shadow_counter + 8'd1;
                        end
                    end
                end
            end
            OP_READ: begin
                case (w.reg_select)
                    REG_DIVIDER: r.read_data = shadow_divider;
                    REG_COUNTER: r.read_data = shadow_counter;
                    REG_RELOAD:  r.read_data = shadow_reload;
                    default:     r.read_data = shadow_control;
                endcase
            end
            OP_WRITE: begin
                case (w.reg_select)
                    REG_DIVIDER: shadow_divider = 8'h00;
                    REG_COUNTER: shadow_counter = w.write_data;
                    REG_RELOAD:  shadow_reload  = w.write_data;
                    default:     shadow_control = w.write_data;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_word make_word(t_opcode op, t_reg_sel rs,
                                           logic [7:0] wd, logic [7:0] cyc);
        t_in_word w;
        w.opcode     = op;
        w.reg_select = rs;
        w.write_data = wd;
        w.cycles     = cyc;
        return w;
    endfunction

    // Tick lengths lean toward zero and the full byte, the smallest and the largest
    // number of cycles that one word can add to the accumulators.
    function automatic logic [7:0] random_cycles();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) return 8'd0;
        if (pick < 35) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // Unconstrained mix of all opcodes, with writes biased toward an enabled
    // timer and a counter close to overflow.
    function automatic t_in_word random_word();
        int unsigned pick;
        t_reg_sel    rs;
        logic [7:0]  wd;
        pick = $urandom_range(99);
        rs   = t_reg_sel'($urandom_range(3));
        wd   = 8'($urandom_range(255));
        if (pick < 55) return make_word(OP_TICK, rs, wd, random_cycles());
        if (pick < 70) return make_word(OP_READ, rs, wd, random_cycles());
        if (pick < 93) begin
            if (rs == REG_COUNTER && $urandom_range(1) == 0)
                wd = 8'($urandom_range(255, 240));
            if (rs == REG_CONTROL && $urandom_range(3) != 0)
                wd[CTRL_ENABLE_BIT] = 1'b1;
            return make_word(OP_WRITE, rs, wd, random_cycles());
        end
        return make_word(OP_UNUSED, rs, wd, random_cycles());
    endfunction

    // Offers one word, idling first at random, and records its expected result
    // once the block takes it. Valid stays high on return so that back-to-back
    // words need no second assignment in the same step.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_timer_result(w));
        words_sent++;
        if (w.opcode == OP_READ) reads_sent++;
    endtask

    // Stops offering words and waits until every owed result has come back.
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_word(make_word(OP_READ, REG_DIVIDER, 8'h00, 8'h00));
        send_word(make_word(OP_READ, REG_COUNTER, 8'h00, 8'h00));
        send_word(make_word(OP_READ, REG_RELOAD,  8'h00, 8'h00));
        send_word(make_word(OP_READ, REG_CONTROL, 8'h00, 8'h00));
    endtask

    task automatic test_register_access();
        send_word(make_word(OP_WRITE, REG_COUNTER, 8'hFF, 8'h00));
        send_word(make_word(OP_WRITE, REG_RELOAD,  8'h00, 8'hFF));
        send_word(make_word(OP_WRITE, REG_CONTROL, 8'hFF, 8'h00));
        send_word(make_word(OP_READ,  REG_COUNTER, 8'h00, 8'h00));
        send_word(make_word(OP_READ,  REG_RELOAD,  8'hFF, 8'hFF));
        send_word(make_word(OP_READ,  REG_CONTROL, 8'h00, 8'h00));
        send_word(make_word(OP_WRITE, REG_COUNTER, 8'h00, 8'h00));
        send_word(make_word(OP_WRITE, REG_RELOAD,  8'hFF, 8'h00));
        send_word(make_word(OP_WRITE, REG_CONTROL, 8'h00, 8'h00));
        // Writing the divider clears it no matter what data comes along.
        send_word(make_word(OP_WRITE, REG_DIVIDER, 8'hFF, 8'h00));
        // The unused opcode with every bit set must change nothing.
        send_word(make_word(OP_UNUSED, REG_CONTROL, 8'hFF, 8'hFF));
    endtask

    task automatic test_tick_cases();
        // One cycle short of a divider period, then the last cycle, then an
        // empty tick.
        send_word(make_word(OP_TICK, REG_DIVIDER, 8'h00, 8'd255));
        send_word(make_word(OP_TICK, REG_DIVIDER, 8'h00, 8'd1));
        send_word(make_word(OP_TICK, REG_DIVIDER, 8'h00, 8'd0));
        // Fastest rate: a full-byte tick leaves the accumulator holding many
        // periods, so a zero-cycle tick still steps the counter into overflow.
        send_word(make_word(OP_WRITE, REG_CONTROL, 8'h05, 8'h00));
        send_word(make_word(OP_WRITE, REG_COUNTER, 8'hFE, 8'h00));
        send_word(make_word(OP_WRITE, REG_RELOAD,  8'hAB, 8'h00));
        send_word(make_word(OP_TICK,  REG_COUNTER, 8'h00, 8'd255));
        send_word(make_word(OP_TICK,  REG_COUNTER, 8'h00, 8'd0));
        // A rate change clears the leftover cycles before the next step.
        send_word(make_word(OP_WRITE, REG_CONTROL, 8'h06, 8'h00));
        send_word(make_word(OP_TICK,  REG_COUNTER, 8'h00, 8'd0));
        send_word(make_word(OP_READ,  REG_COUNTER, 8'h00, 8'h00));
        send_word(make_word(OP_READ,  REG_DIVIDER, 8'h00, 8'h00));
    endtask

    // Well-formed overflow sequences with random content: set a reload value,
    // mostly enable the timer at some rate, park the counter near the top, then tick.
    task automatic test_overflow_sequences(input int unsigned count);
        int unsigned n;
        int unsigned k;
        logic [7:0]  ctl;
        for (n = 0; n < count; n++) begin
            ctl = 8'($urandom_range(255));
            ctl[CTRL_ENABLE_BIT] = ($urandom_range(7) != 0);
            send_word(make_word(OP_WRITE, REG_RELOAD, 8'($urandom_range(255)),
                                random_cycles()));
            send_word(make_word(OP_WRITE, REG_CONTROL, ctl, random_cycles()));
            send_word(make_word(OP_WRITE, REG_COUNTER, 8'($urandom_range(255, 250)),
                                random_cycles()));
            for (k = $urandom_range(8, 3); k != 0; k--)
                send_word(make_word(OP_TICK, t_reg_sel'($urandom_range(3)),
                                    8'($urandom_range(255)), random_cycles()));
            send_word(make_word(OP_READ, t_reg_sel'($urandom_range(3)),
                                8'($urandom_range(255)), random_cycles()));
        end
    endtask

    // Random words with a stretch in the middle where neither side idles.
    task automatic test_random_mix(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++) begin
            idle_pct = (n >= count / 3 && n < count / 3 + 70) ? 0 : IDLE_PCT;
            send_word(random_word());
        end
        idle_pct = IDLE_PCT;
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // words back to back, so both internal registers fill and input ready drops.
    task automatic test_backpressure();
        int unsigned n;
        idle_pct = 0;
        hold_requests++;
        for (n = 0; n < 30; n++) send_word(random_word());
        idle_pct = IDLE_PCT;
        wait_for_drain();
    endtask

    // Bursts separated by pauses in which the sender waits for every result.
    task automatic test_drain_pauses();
        int unsigned b;
        int unsigned n;
        for (b = 0; b < 3; b++) begin
            for (n = 0; n < 15; n++) send_word(random_word());
            wait_for_drain();
        end
    endtask

    // Result receiver: random stalls, plus a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen    <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compares every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: read_data=%0h timer_irq=%0b",
                       out_ch.data.read_data, out_ch.data.timer_irq);
                fail_count++;
            end else begin
                exp_word = pending_results.pop_front();
                results_seen++;
                if (out_ch.data.read_data !== exp_word.read_data) begin
                    $error("read_data: expected %0h, actual %0h",
                           exp_word.read_data, out_ch.data.read_data);
                    fail_count++;
                end
                if (out_ch.data.timer_irq !== exp_word.timer_irq) begin
                    $error("timer_irq: expected %0b, actual %0b",
                           exp_word.timer_irq, out_ch.data.timer_irq);
                    fail_count++;
                end
                if (exp_word.timer_irq) overflows_seen++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("** divider_and_reload_timer_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        // Everything the block sees is known from time zero.
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        shadow_div_acc  = 0;
        shadow_cnt_acc  = 0;
        shadow_divider  = 8'h00;
        shadow_counter  = 8'h00;
        shadow_reload   = 8'h00;
        shadow_control  = 8'h00;
        shadow_rate_sel = 2'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_register_access();
        test_tick_cases();
        test_overflow_sequences(20);
        test_random_mix(160);
        test_backpressure();
        test_drain_pauses();

        // Let any stray result show up before judging the run.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d words (%0d register reads) with random gaps and stalls;",
                 words_sent, reads_sent);
        $display("checked %0d results, %0d of them counter overflows, in %0d cycles.",
                 results_seen, overflows_seen, cycle_count);
        if (fail_count == 0) begin
            $display("** divider_and_reload_timer_unit: PASSED **");
        end else begin
            $display("** divider_and_reload_timer_unit: FAILED **");
        end
        $finish;
    end

endmodule
